// File: hdl/wgf_pkg.sv
// wgf_pkg: shared types and constants of the weighted gaussian fit core
// holds the sequencer states, register indexes and datapath widths
// no dependencies
package wgf_pkg;

  // stream and configuration port widths
  localparam int IN_W       = 32;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // shared multiplier: signed a x signed b
  localparam int MA_W = 33;
  localparam int MB_W = 25;
  localparam int P_W  = MA_W + MB_W;

  // variance and root widths (variance never exceeds 2^30)
  localparam int VAR_W  = 31;
  localparam int ROOT_W = 17;

  // q8.8 limits
  localparam logic [14:0] SPREAD_MAX       = 15'h7fff;
  localparam logic [14:0] PRIOR_SPREAD_RST = 15'd256;
  localparam logic [15:0] MEAN_POS_MAX     = 16'h7fff;
  localparam logic [15:0] MEAN_NEG_MIN     = 16'h8000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_CHANGE   = 2'd0,
    REG_CHECK_SPREAD = 2'd1,
    REG_PRIOR_MEAN   = 2'd2,
    REG_PRIOR_SPREAD = 2'd3
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MXX,
    ST_MWQ,
    ST_ACC,
    ST_CHK,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_MSQ,
    ST_VAR,
    ST_SQ,
    ST_CMP,
    ST_OUT
  } state_t;

endpackage

// File: hdl/wgf_div.sv
// wgf_div: iterative restoring divider, one quotient bit per cycle
// unsigned dividend and nonzero divisor, quotient valid with done
// no dependencies
module wgf_div #(
  parameter int DW = 58,
  parameter int VW = 28
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    dvd;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dsr;
  logic [VW:0]      shifted;
  logic [VW:0]      trial;
  logic             fits;

  // one restoring step
  assign shifted = {rem, dvd[DW-1]};
  assign trial   = shifted - {1'b0, dsr};
  assign fits    = shifted >= {1'b0, dsr};

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out on top, quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[VW-1:0] : shifted[VW-1:0];
      dvd <= {dvd[DW-2:0], fits};
    end
  end

  assign quotient = dvd;

endmodule

// File: hdl/wgf_sqrt.sv
// wgf_sqrt: iterative integer square root, two radicand bits per cycle
// result rounded to nearest, valid with done
// depends on wgf_pkg
module wgf_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wgf_pkg::VAR_W-1:0]   radicand,
  output logic                        done,
  output logic [wgf_pkg::ROOT_W-1:0]  root
);

  import wgf_pkg::*;

  localparam int STEPS = (VAR_W + 1) / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [VAR_W-1:0] rem;
  logic [VAR_W-1:0] res;
  logic [VAR_W-1:0] bitm;
  logic [VAR_W:0]   trial;
  logic             fits;

  assign trial = {1'b0, res} + {1'b0, bitm};
  assign fits  = {1'b0, rem} >= trial;

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // digit-by-digit root
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem  <= radicand;
      res  <= '0;
      bitm <= VAR_W'(1) << (2 * (STEPS - 1));
    end else if (busy) begin
      if (fits) begin
        rem <= rem - trial[VAR_W-1:0];
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  // round up when the remainder exceeds the root
  assign root = ROOT_W'(res) + ROOT_W'(rem > res);

endmodule

// File: hdl/weighted_gaussian_fit_core.sv
// weighted_gaussian_fit_core: weighted mean and standard deviation estimator, top level
// sequencer with one shared multiplier, an iterative divider and square root
// depends on wgf_pkg, wgf_div, wgf_sqrt
//
// Each input word carries a weight (q1.15), a sample (q8.8) and tlast. A sample passes
// through ST_IDLE, ST_MXX, ST_MWQ and ST_ACC: the shared multiplier forms w*x, x*x and
// w*x*x in turn and the three sums grow; s_tready and cfg_ready are high only between
// samples. Only the first MAX_BATCH samples of a batch are summed. The word with tlast
// ends the batch: three runs of the one-bit-per-cycle divider (mean, fine mean, mean
// square) and 16 steps of the root unit, skipped when the weight sum is zero, then the
// result waits until the output register is free. One result word per batch: changed, fit_mean
// and fit_spread in tdata, empty_batch in tuser. The output register lets the next
// batch start while a result waits. Writing a prior register also loads the stored
// estimate.
module weighted_gaussian_fit_core #(
  parameter int MAX_BATCH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // weight [15:0], sample [31:16]
  input  logic        s_tlast,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // changed [0], fit_mean [16:1], fit_spread [31:17]
  output logic [0:0]  m_tuser,   // empty_batch [0]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import wgf_pkg::*;

  localparam int AW    = $clog2(MAX_BATCH);
  localparam int CW    = $clog2(MAX_BATCH + 1);
  localparam int SW_W  = 32 + AW;
  localparam int SQA_W = 46 + AW;
  localparam int VW    = 16 + AW;
  localparam int DW    = SQA_W;

  state_t state, state_next;

  // configuration
  logic [14:0]        max_change;
  logic               check_spread;

  // batch sums and stored estimate
  logic signed [SW_W-1:0] sw;
  logic [SQA_W-1:0]       sq;
  logic [VW-1:0]          swt;
  logic [CW-1:0]          count;
  logic                   take;
  logic signed [15:0]     cur_mean;
  logic [14:0]            cur_spread;

  // latched sample
  logic [15:0]        w_reg;
  logic signed [15:0] x_reg;
  logic               last_reg;

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  p;

  // batch end arithmetic
  logic               neg;
  logic [SW_W-1:0]    mag;
  logic [DW-1:0]      num_mean;
  logic [DW-1:0]      num_fine;
  logic [DW-1:0]      num_sq;
  logic               div_start;
  logic [DW-1:0]      div_dividend;
  logic               div_done;
  logic [DW-1:0]      quotient;
  logic signed [15:0] mean_val;
  logic signed [15:0] mean_q;
  logic [MB_W-1:0]    m16_mag;
  logic signed [MB_W-1:0] m16;
  logic [VAR_W-1:0]   ex2;
  logic [P_W-1:0]     msq_sum;
  logic [VAR_W-1:0]   msq;
  logic [VAR_W-1:0]   var_val;
  logic               sq_start;
  logic               sq_done;
  logic [ROOT_W-1:0]  root;
  logic [14:0]        spread_sat;
  logic signed [16:0] diff_m;
  logic [16:0]        abs_m;
  logic signed [15:0] diff_s;
  logic [15:0]        abs_s;
  logic               changed;

  // result and output registers
  logic               res_changed;
  logic [15:0]        res_mean;
  logic [14:0]        res_spread;
  logic               res_empty;
  logic               out_changed;
  logic [15:0]        out_mean;
  logic [14:0]        out_spread;
  logic               out_empty;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign take      = (count != CW'(MAX_BATCH));

  // dividends for the three divisions
  assign neg      = sw[SW_W-1];
  assign mag      = neg ? SW_W'(-sw) : SW_W'(sw);
  assign num_mean = DW'(mag) + DW'(swt >> 1);
  assign num_fine = DW'({mag, 8'b0}) + DW'(swt >> 1);
  assign num_sq   = DW'(sq);

  // rounded mean, clamped to q8.8
  always_comb begin
    if (neg) begin
      mean_val = (quotient > DW'(32768)) ? MEAN_NEG_MIN : -quotient[15:0];
    end else begin
      mean_val = (quotient > DW'(32767)) ? MEAN_POS_MAX : quotient[15:0];
    end
  end

  // mean in q.16, at most 2^23 in magnitude
  assign m16_mag = MB_W'(quotient[MB_W-2:0]);

  // variance from mean square and squared mean
  assign msq_sum = P_W'(p) + P_W'(32768);
  assign msq     = msq_sum[VAR_W+15:16];
  assign var_val = (ex2 > msq) ? ex2 - msq : '0;

  // spread saturation and change test
  assign spread_sat = (root > ROOT_W'(SPREAD_MAX)) ? SPREAD_MAX : root[14:0];
  assign diff_m     = 17'(mean_q) - 17'(cur_mean);
  assign abs_m      = diff_m[16] ? 17'(-diff_m) : 17'(diff_m);
  assign diff_s     = $signed({1'b0, spread_sat}) - $signed({1'b0, cur_spread});
  assign abs_s      = diff_s[15] ? 16'(-diff_s) : 16'(diff_s);
  assign changed    = (abs_m >= 17'(max_change)) ||
                      (check_spread && (abs_s >= 16'(max_change)));

  // multiplier operand select
  always_comb begin
    case (state)
      ST_IDLE: begin
        mul_a = MA_W'($signed(s_tdata[31:16]));
        mul_b = $signed(MB_W'(s_tdata[15:0]));
      end
      ST_MXX: begin
        mul_a = MA_W'(x_reg);
        mul_b = MB_W'(x_reg);
      end
      ST_MWQ: begin
        mul_a = p[MA_W-1:0];
        mul_b = $signed(MB_W'(w_reg));
      end
      ST_MSQ: begin
        mul_a = MA_W'(m16);
        mul_b = m16;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit starts
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = num_mean;
    sq_start     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_MXX;
      end
      ST_MXX: state_next = ST_MWQ;
      ST_MWQ: state_next = ST_ACC;
      ST_ACC: state_next = last_reg ? ST_CHK : ST_IDLE;
      ST_CHK: begin
        if (swt == '0) begin
          state_next = ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_D1;
        end
      end
      ST_D1: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = num_fine;
          state_next   = ST_D2;
        end
      end
      ST_D2: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = num_sq;
          state_next   = ST_D3;
        end
      end
      ST_D3: begin
        if (div_done) state_next = ST_MSQ;
      end
      ST_MSQ: state_next = ST_VAR;
      ST_VAR: begin
        sq_start   = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        if (sq_done) state_next = ST_CMP;
      end
      ST_CMP: state_next = ST_OUT;
      ST_OUT: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration, sums, stored estimate and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      max_change   <= '0;
      check_spread <= 1'b0;
      cur_mean     <= '0;
      cur_spread   <= PRIOR_SPREAD_RST;
      sw           <= '0;
      sq           <= '0;
      swt          <= '0;
      count        <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAX_CHANGE:   max_change   <= cfg_data[14:0];
          REG_CHECK_SPREAD: check_spread <= cfg_data[0];
          REG_PRIOR_MEAN:   cur_mean     <= cfg_data;
          REG_PRIOR_SPREAD: cur_spread   <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (state == ST_MXX && take) begin
        sw <= sw + p[SW_W-1:0];
      end
      if (state == ST_ACC && take) begin
        sq    <= sq + p[SQA_W-1:0];
        swt   <= swt + VW'(w_reg);
        count <= count + 1'b1;
      end
      if ((state == ST_CHK && swt == '0) || state == ST_CMP) begin
        sw    <= '0;
        sq    <= '0;
        swt   <= '0;
        count <= '0;
      end
      if (state == ST_CMP && changed) begin
        cur_mean   <= mean_q;
        cur_spread <= spread_sat;
      end
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
    if (state == ST_IDLE && s_tvalid) begin
      w_reg    <= s_tdata[15:0];
      x_reg    <= s_tdata[31:16];
      last_reg <= s_tlast;
    end
    if (state == ST_D1 && div_done) mean_q <= mean_val;
    if (state == ST_D2 && div_done) m16 <= neg ? -m16_mag : m16_mag;
    if (state == ST_D3 && div_done) ex2 <= quotient[VAR_W-1:0];
    if (state == ST_CHK && swt == '0) begin
      res_changed <= 1'b0;
      res_mean    <= '0;
      res_spread  <= '0;
      res_empty   <= 1'b1;
    end
    if (state == ST_CMP) begin
      res_changed <= changed;
      res_mean    <= mean_q;
      res_spread  <= spread_sat;
      res_empty   <= 1'b0;
    end
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      out_changed <= res_changed;
      out_mean    <= res_mean;
      out_spread  <= res_spread;
      out_empty   <= res_empty;
    end
  end

  assign m_tdata = {out_spread, out_mean, out_changed};
  assign m_tuser = out_empty;

  // shared divider
  wgf_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (swt),
    .done     (div_done),
    .quotient (quotient)
  );

  // square root unit
  wgf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (var_val),
    .done     (sq_done),
    .root     (root)
  );

endmodule
